/* rtl/core/lphs_pkg.sv */
// Shared types and constants for the linear-probing hash set.
// Used by lphs_keyprep and linear_probe_hash_set_core; no dependencies.

package lphs_pkg;

	// Table geometry
	localparam int TABLE_SLOTS     = 26;
	localparam int MAX_KEY_LETTERS = 10;
	localparam int SLOT_W          = $clog2(TABLE_SLOTS);
	localparam int CNT_W           = $clog2(TABLE_SLOTS + 1);

	// Key format: five bits per letter, first letter lowest
	localparam int LETTER_W        = 5;
	localparam int KEY_W           = 50;
	localparam int LEN_W           = 4;
	localparam int KEY_LETTERS     = KEY_W / LETTER_W;
	localparam int ENTRY_W         = KEY_W + LEN_W;
	localparam int HOME_CMP_W      = (CNT_W > LETTER_W) ? CNT_W : LETTER_W;

	// Port field widths
	localparam int CMD_W           = 2;
	localparam int OUTCOME_W       = 3;
	localparam int SLOT_PORT_W     = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD    = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_DUMP   = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [OUTCOME_W-1:0] {
		OUT_INSERTED = 3'd0,
		OUT_PRESENT  = 3'd1,
		OUT_FULL     = 3'd2,
		OUT_REMOVED  = 3'd3,
		OUT_NOTFOUND = 3'd4,
		OUT_LISTED   = 3'd5,
		OUT_EMPTY    = 3'd6
	} outcome_t;

	typedef enum logic [1:0] {
		SLOT_OCCUPIED = 2'b00,
		SLOT_NEVER    = 2'b01,
		SLOT_TOMB     = 2'b10
	} slot_status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_EMIT,
		ST_DUMP
	} state_t;

	// Normalised key handed from the key preparation stage to the sequencer
	typedef struct packed {
		logic [KEY_W-1:0]  value;
		logic [LEN_W-1:0]  length;
		logic [SLOT_W-1:0] home;
	} key_info_t;

endpackage

/* rtl/core/lphs_keyprep.sv */
// Key normalisation: clamps the length, clears unused letters, derives home slot.
// Depends on lphs_pkg.

module lphs_keyprep (
	input  logic [lphs_pkg::KEY_W-1:0] key_value,
	input  logic [lphs_pkg::LEN_W-1:0] key_length,
	output lphs_pkg::key_info_t        info
);

	logic [lphs_pkg::LEN_W-1:0]      eff_len;
	logic [lphs_pkg::KEY_W-1:0]      masked;
	logic [lphs_pkg::LETTER_W-1:0]   last_letter;
	logic [lphs_pkg::HOME_CMP_W-1:0] letter_x;
	logic [lphs_pkg::HOME_CMP_W-1:0] home_x;

	// Clamp length into 1..MAX_KEY_LETTERS
	always_comb begin
		priority if (key_length == '0) begin
			eff_len = lphs_pkg::LEN_W'(1);
		end else if (key_length > lphs_pkg::LEN_W'(lphs_pkg::MAX_KEY_LETTERS)) begin
			eff_len = lphs_pkg::LEN_W'(lphs_pkg::MAX_KEY_LETTERS);
		end else begin
			eff_len = key_length;
		end
	end

	// Keep letters below the length; pick out the last one
	always_comb begin
		masked      = '0;
		last_letter = '0;
		for (int i = 0; i < lphs_pkg::KEY_LETTERS; i++) begin
			if (lphs_pkg::LEN_W'(i) < eff_len) begin
				masked[i*lphs_pkg::LETTER_W +: lphs_pkg::LETTER_W] =
					key_value[i*lphs_pkg::LETTER_W +: lphs_pkg::LETTER_W];
			end
			if (lphs_pkg::LEN_W'(i + 1) == eff_len) begin
				last_letter = key_value[i*lphs_pkg::LETTER_W +: lphs_pkg::LETTER_W];
			end
		end
	end

	// Letter modulo table size: the letter is below twice the size
	always_comb begin
		letter_x = lphs_pkg::HOME_CMP_W'(last_letter);
		if (letter_x >= lphs_pkg::HOME_CMP_W'(lphs_pkg::TABLE_SLOTS)) begin
			home_x = letter_x - lphs_pkg::HOME_CMP_W'(lphs_pkg::TABLE_SLOTS);
		end else begin
			home_x = letter_x;
		end
	end

	assign info.value  = masked;
	assign info.length = eff_len;
	assign info.home   = lphs_pkg::SLOT_W'(home_x);

endmodule

/* rtl/core/lphs_ram.sv */
// Single-port-write, single-port-read synchronous RAM with registered read data.
// No dependencies.

module lphs_ram #(
	parameter int DEPTH  = 26,
	parameter int WIDTH  = 54,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read data holds while the read enable is low
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/core/linear_probe_hash_set_core.sv */
// Open-addressed set of TABLE_SLOTS short keys with linear probing and tombstones.
// Depends on lphs_pkg, lphs_keyprep and lphs_ram.
//
// One request is in work at a time. Add and delete walk the chain from the home
// slot, reading one slot of the key RAM per cycle; the walk stops at a hit, at a
// never-used slot or after a full turn. The walk is paced by the single read port
// of the key RAM and its registered read data. A dump scans every slot in order,
// one per cycle while the response side does not stall. Slot status lives in
// flip-flops cleared by reset, so the block is ready in the first cycle after
// reset. A response still waiting to be taken does not hold off the next request.

module linear_probe_hash_set_core (
	input  logic                             clk,
	input  logic                             arst_n,
	// request channel
	input  logic                             req_valid,
	output logic                             req_stall,
	input  logic [lphs_pkg::CMD_W-1:0]       cmd,
	input  logic [lphs_pkg::KEY_W-1:0]       key_value,
	input  logic [lphs_pkg::LEN_W-1:0]       key_length,
	// response channel
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output logic [lphs_pkg::OUTCOME_W-1:0]   outcome,
	output logic [lphs_pkg::KEY_W-1:0]       entry_value,
	output logic [lphs_pkg::LEN_W-1:0]       entry_length,
	output logic [lphs_pkg::SLOT_PORT_W-1:0] slot,
	output logic                             last
);

	lphs_pkg::state_t      state_q, state_nxt;
	lphs_pkg::key_info_t   in_key;
	lphs_pkg::slot_status_t status_q [lphs_pkg::TABLE_SLOTS];
	logic [lphs_pkg::TABLE_SLOTS-1:0] occ_vec;
	logic [lphs_pkg::TABLE_SLOTS-1:0] occ_above;

	// request held for the walk
	lphs_pkg::cmd_t              cmd_q;
	logic [lphs_pkg::KEY_W-1:0]  key_q;
	logic [lphs_pkg::LEN_W-1:0]  len_q;
	logic [lphs_pkg::SLOT_W-1:0] home_q;

	// read issue and read-data stage
	logic [lphs_pkg::SLOT_W-1:0] issue_addr_q;
	logic [lphs_pkg::SLOT_W-1:0] issue_addr_inc;
	logic [lphs_pkg::CNT_W-1:0]  issue_cnt_q;
	logic                        vis_v_s1;
	logic [lphs_pkg::SLOT_W-1:0] vis_addr_s1;
	logic                        vis_last_s1;

	// first reusable slot met on the walk, used by an add
	logic                        have_free_q;
	logic [lphs_pkg::SLOT_W-1:0] free_q;

	// pending single result
	lphs_pkg::outcome_t          res_outcome_q, res_outcome_nxt;
	logic [lphs_pkg::KEY_W-1:0]  res_value_q, res_value_nxt;
	logic [lphs_pkg::LEN_W-1:0]  res_len_q, res_len_nxt;
	logic [lphs_pkg::SLOT_W-1:0] res_slot_q, res_slot_nxt;

	// response register
	logic                        rsp_valid_q;
	lphs_pkg::outcome_t          rsp_outcome_q;
	logic [lphs_pkg::KEY_W-1:0]  rsp_value_q;
	logic [lphs_pkg::LEN_W-1:0]  rsp_len_q;
	logic [lphs_pkg::SLOT_W-1:0] rsp_slot_q;
	logic                        rsp_last_q;

	// RAM ports
	logic                          ram_wr_en;
	logic                          ram_rd_en;
	logic [lphs_pkg::ENTRY_W-1:0]  ram_rd_data;
	logic [lphs_pkg::KEY_W-1:0]    rd_key;
	logic [lphs_pkg::LEN_W-1:0]    rd_len;

	// control
	logic                        accept;
	logic                        out_free;
	lphs_pkg::slot_status_t      vis_status;
	logic                        vis_occ;
	logic                        hit;
	logic                        free_now_v;
	logic [lphs_pkg::SLOT_W-1:0] free_now;
	logic                        probe_done;
	logic                        issue_go;
	logic                        dump_block;
	logic                        dump_emit;
	logic                        dump_done;
	logic                        load_emit;
	logic                        set_occ;
	logic                        set_tomb;
	logic                        res_load;

	lphs_keyprep u_keyprep (
		.key_value  (key_value),
		.key_length (key_length),
		.info       (in_key)
	);

	lphs_ram #(
		.DEPTH (lphs_pkg::TABLE_SLOTS),
		.WIDTH (lphs_pkg::ENTRY_W)
	) u_key_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (free_now),
		.wr_data ({key_q, len_q}),
		.rd_en   (ram_rd_en),
		.rd_addr (issue_addr_q),
		.rd_data (ram_rd_data)
	);

	assign rd_key = ram_rd_data[lphs_pkg::ENTRY_W-1 -: lphs_pkg::KEY_W];
	assign rd_len = ram_rd_data[lphs_pkg::LEN_W-1:0];

	// Occupancy view of the status flops
	always_comb begin
		for (int i = 0; i < lphs_pkg::TABLE_SLOTS; i++) begin
			occ_vec[i] = (status_q[i] == lphs_pkg::SLOT_OCCUPIED);
		end
	end
	assign occ_above = (occ_vec >> vis_addr_s1) >> 1;

	assign accept   = req_valid && !req_stall;
	assign out_free = !rsp_valid_q || !rsp_stall;

	// Slot under examination this cycle
	assign vis_status = status_q[vis_addr_s1];
	assign vis_occ    = (vis_status == lphs_pkg::SLOT_OCCUPIED);
	assign hit        = vis_occ && (rd_key == key_q) && (rd_len == len_q);
	assign free_now_v = have_free_q || !vis_occ;
	assign free_now   = have_free_q ? free_q : vis_addr_s1;

	assign issue_addr_inc = (issue_addr_q == lphs_pkg::SLOT_W'(lphs_pkg::TABLE_SLOTS - 1)) ?
		'0 : issue_addr_q + lphs_pkg::SLOT_W'(1);

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			lphs_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (lphs_pkg::cmd_t'(cmd))
						lphs_pkg::CMD_ADD,
						lphs_pkg::CMD_DELETE: state_nxt = lphs_pkg::ST_PROBE;
						lphs_pkg::CMD_DUMP:   state_nxt = (|occ_vec) ?
							lphs_pkg::ST_DUMP : lphs_pkg::ST_EMIT;
						lphs_pkg::CMD_NONE:   state_nxt = lphs_pkg::ST_IDLE;
					endcase
				end
			end
			lphs_pkg::ST_PROBE: begin
				if (probe_done) begin
					state_nxt = lphs_pkg::ST_EMIT;
				end
			end
			lphs_pkg::ST_EMIT: begin
				if (out_free) begin
					state_nxt = lphs_pkg::ST_IDLE;
				end
			end
			lphs_pkg::ST_DUMP: begin
				if (dump_done) begin
					state_nxt = lphs_pkg::ST_IDLE;
				end
			end
		endcase
	end

	// Control outputs
	always_comb begin
		req_stall  = 1'b1;
		probe_done = 1'b0;
		issue_go   = 1'b0;
		dump_block = 1'b0;
		dump_emit  = 1'b0;
		dump_done  = 1'b0;
		load_emit  = 1'b0;
		unique case (state_q)
			lphs_pkg::ST_IDLE: begin
				req_stall = 1'b0;
			end
			lphs_pkg::ST_PROBE: begin
				probe_done = vis_v_s1 && (hit || vis_status == lphs_pkg::SLOT_NEVER ||
					vis_last_s1);
				issue_go   = !probe_done &&
					(issue_cnt_q != lphs_pkg::CNT_W'(lphs_pkg::TABLE_SLOTS));
			end
			lphs_pkg::ST_EMIT: begin
				load_emit = out_free;
			end
			lphs_pkg::ST_DUMP: begin
				dump_block = vis_v_s1 && vis_occ && !out_free;
				dump_emit  = vis_v_s1 && vis_occ && out_free;
				issue_go   = !dump_block &&
					(issue_cnt_q != lphs_pkg::CNT_W'(lphs_pkg::TABLE_SLOTS));
				dump_done  = !dump_block &&
					(issue_cnt_q == lphs_pkg::CNT_W'(lphs_pkg::TABLE_SLOTS));
			end
		endcase
	end

	assign ram_rd_en = issue_go;

	// Table updates at the end of a walk
	assign set_occ   = probe_done && !hit && (cmd_q == lphs_pkg::CMD_ADD) && free_now_v;
	assign set_tomb  = probe_done && hit && (cmd_q == lphs_pkg::CMD_DELETE);
	assign ram_wr_en = set_occ;

	// Single result of an add, delete or empty dump
	always_comb begin
		res_load        = 1'b0;
		res_outcome_nxt = res_outcome_q;
		res_value_nxt   = key_q;
		res_len_nxt     = len_q;
		res_slot_nxt    = home_q;
		if (accept && (lphs_pkg::cmd_t'(cmd) == lphs_pkg::CMD_DUMP)) begin
			res_load        = 1'b1;
			res_outcome_nxt = lphs_pkg::OUT_EMPTY;
			res_value_nxt   = '0;
			res_len_nxt     = '0;
			res_slot_nxt    = '0;
		end else if (probe_done) begin
			res_load = 1'b1;
			if (cmd_q == lphs_pkg::CMD_ADD) begin
				priority if (hit) begin
					res_outcome_nxt = lphs_pkg::OUT_PRESENT;
					res_slot_nxt    = vis_addr_s1;
				end else if (free_now_v) begin
					res_outcome_nxt = lphs_pkg::OUT_INSERTED;
					res_slot_nxt    = free_now;
				end else begin
					res_outcome_nxt = lphs_pkg::OUT_FULL;
				end
			end else begin
				if (hit) begin
					res_outcome_nxt = lphs_pkg::OUT_REMOVED;
					res_slot_nxt    = vis_addr_s1;
				end else begin
					res_outcome_nxt = lphs_pkg::OUT_NOTFOUND;
				end
			end
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lphs_pkg::ST_IDLE;
			vis_v_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < lphs_pkg::TABLE_SLOTS; i++) begin
				status_q[i] <= lphs_pkg::SLOT_NEVER;
			end
		end else begin
			state_q <= state_nxt;
			if (set_occ) begin
				status_q[free_now] <= lphs_pkg::SLOT_OCCUPIED;
			end
			if (set_tomb) begin
				status_q[vis_addr_s1] <= lphs_pkg::SLOT_TOMB;
			end
			// read-data stage holds while a dump entry waits for the response side
			if (!dump_block) begin
				vis_v_s1 <= issue_go;
			end
			if (load_emit || dump_emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q        <= lphs_pkg::cmd_t'(cmd);
			key_q        <= in_key.value;
			len_q        <= in_key.length;
			home_q       <= in_key.home;
			issue_cnt_q  <= '0;
			have_free_q  <= 1'b0;
			issue_addr_q <= (lphs_pkg::cmd_t'(cmd) == lphs_pkg::CMD_DUMP) ? '0 : in_key.home;
		end else if (issue_go) begin
			issue_addr_q <= issue_addr_inc;
			issue_cnt_q  <= issue_cnt_q + lphs_pkg::CNT_W'(1);
		end
		if (issue_go) begin
			vis_addr_s1 <= issue_addr_q;
			vis_last_s1 <= (issue_cnt_q == lphs_pkg::CNT_W'(lphs_pkg::TABLE_SLOTS - 1));
		end
		// remember the first reusable slot of the chain
		if (state_q == lphs_pkg::ST_PROBE && vis_v_s1 && !have_free_q && !vis_occ) begin
			have_free_q <= 1'b1;
			free_q      <= vis_addr_s1;
		end
		if (res_load) begin
			res_outcome_q <= res_outcome_nxt;
			res_value_q   <= res_value_nxt;
			res_len_q     <= res_len_nxt;
			res_slot_q    <= res_slot_nxt;
		end
		// response register
		if (load_emit) begin
			rsp_outcome_q <= res_outcome_q;
			rsp_value_q   <= res_value_q;
			rsp_len_q     <= res_len_q;
			rsp_slot_q    <= res_slot_q;
			rsp_last_q    <= 1'b1;
		end else if (dump_emit) begin
			rsp_outcome_q <= lphs_pkg::OUT_LISTED;
			rsp_value_q   <= rd_key;
			rsp_len_q     <= rd_len;
			rsp_slot_q    <= vis_addr_s1;
			rsp_last_q    <= ~|occ_above;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign outcome      = rsp_outcome_q;
	assign entry_value  = rsp_value_q;
	assign entry_length = rsp_len_q;
	assign slot         = lphs_pkg::SLOT_PORT_W'(rsp_slot_q);
	assign last         = rsp_last_q;

endmodule

/* verif/tb_linear_probe_hash_set_core.sv */
// Self-checking testbench for linear_probe_hash_set_core: add, delete and dump requests
// are checked against a scoreboard that mirrors the slot table. Depends on lphs_pkg and the RTL.

module tb_linear_probe_hash_set_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RUN_LIMIT     = 200000;
	localparam int DRAIN_CYCLES  = 40;
	localparam int LONG_HOLD     = 150;
	localparam int POOL_CAPACITY = 48;

	typedef struct packed {
		lphs_pkg::outcome_t               outcome;
		logic [lphs_pkg::KEY_W-1:0]       value;
		logic [lphs_pkg::LEN_W-1:0]       length;
		logic [lphs_pkg::SLOT_PORT_W-1:0] slot;
		logic                             last;
	} set_response_t;

	// Mirror of the slot table plus the queue of responses still owed by the block
	class hash_set_scoreboard;
		lphs_pkg::slot_status_t     status_of [lphs_pkg::TABLE_SLOTS];
		logic [lphs_pkg::KEY_W-1:0] key_of    [lphs_pkg::TABLE_SLOTS];
		logic [lphs_pkg::LEN_W-1:0] length_of [lphs_pkg::TABLE_SLOTS];
		set_response_t              owed [$];
		int unsigned                errors;

		function new();
			foreach (status_of[i]) begin
				status_of[i] = lphs_pkg::SLOT_NEVER;
				key_of[i]    = '0;
				length_of[i] = '0;
			end
			errors = 0;
		endfunction

		function int pending();
			return owed.size();
		endfunction

		function void owe(lphs_pkg::outcome_t o, logic [lphs_pkg::KEY_W-1:0] v, int l, int s,
				bit fin);
			set_response_t r;
			r.outcome = o;
			r.value   = v;
			r.length  = l[lphs_pkg::LEN_W-1:0];
			r.slot    = s[lphs_pkg::SLOT_PORT_W-1:0];
			r.last    = fin;
			owed.push_back(r);
		endfunction

		// Walk the table for one accepted request and queue the responses it causes
		function void note_request(lphs_pkg::cmd_t c, logic [lphs_pkg::KEY_W-1:0] raw_value,
				logic [lphs_pkg::LEN_W-1:0] raw_length);
			int                         eff_len;
			int                         home;
			int                         s;
			int                         n_listed;
			int                         n_seen;
			int                         free_slot;
			bit                         have_free;
			logic [lphs_pkg::KEY_W-1:0] key;
			if (c == lphs_pkg::CMD_NONE)
				return;
			if (c == lphs_pkg::CMD_DUMP) begin
				n_listed = 0;
				n_seen   = 0;
				foreach (status_of[i])
					if (status_of[i] == lphs_pkg::SLOT_OCCUPIED)
						n_listed++;
				if (n_listed == 0) begin
					owe(lphs_pkg::OUT_EMPTY, '0, 0, 0, 1'b1);
					return;
				end
				foreach (status_of[i]) begin
					if (status_of[i] == lphs_pkg::SLOT_OCCUPIED) begin
						n_seen++;
						owe(lphs_pkg::OUT_LISTED, key_of[i], length_of[i], i,
							n_seen == n_listed);
					end
				end
				return;
			end
			// normalise length, clear letters beyond it, home is the last letter modulo the table size
			eff_len = (raw_length == 0) ? 1 :
				(raw_length > lphs_pkg::MAX_KEY_LETTERS) ? lphs_pkg::MAX_KEY_LETTERS :
				raw_length;
			key  = raw_value & ({lphs_pkg::KEY_W{1'b1}} >>
				(lphs_pkg::KEY_W - lphs_pkg::LETTER_W * eff_len));
			home = key[lphs_pkg::LETTER_W*(eff_len-1) +: lphs_pkg::LETTER_W] %
				lphs_pkg::TABLE_SLOTS;
			s    = home;
			if (c == lphs_pkg::CMD_ADD) begin
				have_free = 1'b0;
				free_slot = 0;
				for (int i = 0; i < lphs_pkg::TABLE_SLOTS; i++) begin
					if (status_of[s] == lphs_pkg::SLOT_OCCUPIED && key_of[s] == key &&
							length_of[s] == eff_len) begin
						owe(lphs_pkg::OUT_PRESENT, key, eff_len, s, 1'b1);
						return;
					end
					if (!have_free && status_of[s] != lphs_pkg::SLOT_OCCUPIED) begin
						have_free = 1'b1;
						free_slot = s;
					end
					if (status_of[s] == lphs_pkg::SLOT_NEVER)
						break;
					s = (s + 1) % lphs_pkg::TABLE_SLOTS;
				end
				if (have_free) begin
					status_of[free_slot] = lphs_pkg::SLOT_OCCUPIED;
					key_of[free_slot]    = key;
					length_of[free_slot] = eff_len[lphs_pkg::LEN_W-1:0];
					owe(lphs_pkg::OUT_INSERTED, key, eff_len, free_slot, 1'b1);
				end else begin
					owe(lphs_pkg::OUT_FULL, key, eff_len, home, 1'b1);
				end
				return;
			end
			// delete: same walk, a hit becomes a tombstone
			for (int i = 0; i < lphs_pkg::TABLE_SLOTS; i++) begin
				if (status_of[s] == lphs_pkg::SLOT_OCCUPIED && key_of[s] == key &&
						length_of[s] == eff_len) begin
					status_of[s] = lphs_pkg::SLOT_TOMB;
					owe(lphs_pkg::OUT_REMOVED, key, eff_len, s, 1'b1);
					return;
				end
				if (status_of[s] == lphs_pkg::SLOT_NEVER)
					break;
				s = (s + 1) % lphs_pkg::TABLE_SLOTS;
			end
			owe(lphs_pkg::OUT_NOTFOUND, key, eff_len, home, 1'b1);
		endfunction

		function void report(string what, set_response_t exp, set_response_t got);
			errors++;
			if (errors <= 10)
				$display("mismatch (%s): exp outcome %0d value %h len %0d slot %0d last %b",
					what, exp.outcome, exp.value, exp.length, exp.slot, exp.last,
					" | got outcome %0d value %h len %0d slot %0d last %b",
					got.outcome, got.value, got.length, got.slot, got.last);
		endfunction

		function void check_response(set_response_t got);
			set_response_t exp;
			if (owed.size() == 0) begin
				report("unexpected response", '0, got);
				return;
			end
			exp = owed.pop_front();
			if (got.outcome !== exp.outcome || got.value !== exp.value ||
					got.length !== exp.length || got.slot !== exp.slot ||
					got.last !== exp.last)
				report("field", exp, got);
		endfunction
	endclass

	logic                             clk;
	logic                             arst_n;
	logic                             req_valid;
	logic                             req_stall;
	logic [lphs_pkg::CMD_W-1:0]       cmd;
	logic [lphs_pkg::KEY_W-1:0]       key_value;
	logic [lphs_pkg::LEN_W-1:0]       key_length;
	logic                             rsp_valid;
	logic                             rsp_stall;
	logic [lphs_pkg::OUTCOME_W-1:0]   outcome;
	logic [lphs_pkg::KEY_W-1:0]       entry_value;
	logic [lphs_pkg::LEN_W-1:0]       entry_length;
	logic [lphs_pkg::SLOT_PORT_W-1:0] slot;
	logic                             last;

	hash_set_scoreboard         tracker;
	bit                         quiet;
	int                         hold_off_cycles;
	logic [lphs_pkg::KEY_W-1:0] pool_value [$];
	logic [lphs_pkg::LEN_W-1:0] pool_length [$];

	linear_probe_hash_set_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.cmd          (cmd),
		.key_value    (key_value),
		.key_length   (key_length),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.outcome      (outcome),
		.entry_value  (entry_value),
		.entry_length (entry_length),
		.slot         (slot),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	initial begin
		repeat (RUN_LIMIT) @(posedge clk);
		$display("tb: failure");
		$finish;
	end

	// Response side: check each accepted response, then choose next cycle's stall
	initial begin
		int   stall_burst;
		logic stall_next;
		stall_burst = 0;
		rsp_stall   = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall)
				tracker.check_response('{lphs_pkg::outcome_t'(outcome), entry_value,
					entry_length, slot, last});
			if (hold_off_cycles > 0) begin
				hold_off_cycles--;
				stall_next = 1'b1;
			end else if (stall_burst > 0) begin
				stall_burst--;
				stall_next = 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				stall_burst = $urandom_range(0, 2);
				stall_next  = 1'b1;
			end else begin
				stall_next = 1'b0;
			end
			rsp_stall <= stall_next;
		end
	end

	// Offer one request, with an optional idle burst first, and hold it until taken
	task automatic send_request(lphs_pkg::cmd_t c, logic [lphs_pkg::KEY_W-1:0] v,
			logic [lphs_pkg::LEN_W-1:0] l);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		req_valid  <= 1'b1;
		cmd        <= c;
		key_value  <= v;
		key_length <= l;
		do @(posedge clk); while (req_stall);
		tracker.note_request(c, v, l);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (tracker.pending() != 0);
	endtask

	function automatic logic [lphs_pkg::KEY_W-1:0] random_bits();
		return lphs_pkg::KEY_W'({$urandom, $urandom});
	endfunction

	function automatic logic [lphs_pkg::LEN_W-1:0] random_length();
		return lphs_pkg::LEN_W'($urandom_range(0, 15));
	endfunction

	// New key: mostly short, last letter clustered so that chains form
	task automatic make_key(output logic [lphs_pkg::KEY_W-1:0] v,
			output logic [lphs_pkg::LEN_W-1:0] l);
		int pick;
		int eff;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			l = lphs_pkg::LEN_W'($urandom_range(1, 3));
		else if (pick < 8)
			l = lphs_pkg::LEN_W'($urandom_range(4, lphs_pkg::MAX_KEY_LETTERS));
		else
			l = random_length();
		eff = (l == 0) ? 1 : (l > lphs_pkg::MAX_KEY_LETTERS) ? lphs_pkg::MAX_KEY_LETTERS : l;
		v = random_bits();
		v[lphs_pkg::LETTER_W*(eff-1) +: lphs_pkg::LETTER_W] = ($urandom_range(0, 3) == 0) ?
			lphs_pkg::LETTER_W'($urandom_range(0, 31)) :
			lphs_pkg::LETTER_W'($urandom_range(0, 5));
	endtask

	task automatic add_fresh();
		logic [lphs_pkg::KEY_W-1:0] v;
		logic [lphs_pkg::LEN_W-1:0] l;
		make_key(v, l);
		if (pool_value.size() >= POOL_CAPACITY) begin
			void'(pool_value.pop_front());
			void'(pool_length.pop_front());
		end
		pool_value.push_back(v);
		pool_length.push_back(l);
		send_request(lphs_pkg::CMD_ADD, v, l);
	endtask

	// Mostly well-formed traffic on known keys, some unknown keys and noise
	task automatic random_mix(int count);
		int                         pick;
		int                         idx;
		logic [lphs_pkg::KEY_W-1:0] v;
		logic [lphs_pkg::LEN_W-1:0] l;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			idx  = (pool_value.size() > 0) ? $urandom_range(0, pool_value.size() - 1) : 0;
			if (pick < 45) begin
				if (pool_value.size() > 0 && pick < 15)
					send_request(lphs_pkg::CMD_ADD, pool_value[idx], pool_length[idx]);
				else
					add_fresh();
			end else if (pick < 80) begin
				if (pool_value.size() > 0 && pick < 72) begin
					send_request(lphs_pkg::CMD_DELETE, pool_value[idx], pool_length[idx]);
				end else begin
					make_key(v, l);
					send_request(lphs_pkg::CMD_DELETE, v, l);
				end
			end else if (pick < 90) begin
				send_request(lphs_pkg::CMD_DUMP, random_bits(), random_length());
			end else if (pick < 94) begin
				send_request(lphs_pkg::CMD_NONE, random_bits(), random_length());
			end else begin
				send_request(lphs_pkg::cmd_t'($urandom_range(0, 3)), random_bits(),
					random_length());
			end
		end
	endtask

	// Stimulus
	initial begin
		arst_n          = 1'b0;
		req_valid       = 1'b0;
		cmd             = lphs_pkg::CMD_NONE;
		key_value       = '0;
		key_length      = '0;
		quiet           = 1'b0;
		hold_off_cycles = 0;
		tracker         = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty dump, length and value matching, clamped lengths, high letters
		send_request(lphs_pkg::CMD_DUMP, '0, '0);
		send_request(lphs_pkg::CMD_ADD, '0, 4'd1);
		send_request(lphs_pkg::CMD_ADD, '0, 4'd2);
		send_request(lphs_pkg::CMD_ADD, '0, 4'd1);
		send_request(lphs_pkg::CMD_ADD, {lphs_pkg::KEY_W{1'b1}}, 4'd0);
		send_request(lphs_pkg::CMD_ADD, {lphs_pkg::KEY_W{1'b1}}, 4'd15);
		send_request(lphs_pkg::CMD_ADD, random_bits(), 4'd11);
		send_request(lphs_pkg::CMD_ADD, 50'd26, 4'd1);
		send_request(lphs_pkg::CMD_ADD, 50'd31 << (lphs_pkg::LETTER_W * 2), 4'd3);
		send_request(lphs_pkg::CMD_DELETE, 50'd3, 4'd1);
		send_request(lphs_pkg::CMD_DELETE, '0, 4'd2);
		send_request(lphs_pkg::CMD_DELETE, '0, 4'd2);
		// duplicate sits beyond the tombstone; a new key reuses the tombstone
		send_request(lphs_pkg::CMD_ADD, 50'd26, 4'd1);
		send_request(lphs_pkg::CMD_ADD, '0, 4'd3);
		send_request(lphs_pkg::CMD_NONE, {lphs_pkg::KEY_W{1'b1}}, 4'd15);
		send_request(lphs_pkg::CMD_DUMP, {lphs_pkg::KEY_W{1'b1}}, 4'd15);
		send_request(lphs_pkg::CMD_DELETE, {lphs_pkg::KEY_W{1'b1}}, 4'd12);
		send_request(lphs_pkg::CMD_DELETE, {lphs_pkg::KEY_W{1'b1}}, 4'd0);
		send_request(lphs_pkg::CMD_DUMP, '0, '0);

		random_mix(35);
		// long hold on the response side while requests keep coming
		hold_off_cycles = LONG_HOLD;
		random_mix(40);
		wait_drained();

		// drive the table to full, then churn it through tombstones
		repeat (32) add_fresh();
		send_request(lphs_pkg::CMD_DUMP, '0, '0);
		random_mix(30);
		while (pool_value.size() > 0) begin
			send_request(lphs_pkg::CMD_DELETE, pool_value[0], pool_length[0]);
			void'(pool_value.pop_front());
			void'(pool_length.pop_front());
		end
		send_request(lphs_pkg::CMD_DUMP, '0, '0);

		// closing stretch with no idling on either side
		quiet = 1'b1;
		random_mix(35);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
